>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check on the rising clock edge
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// plain invariant on the rising clock edge
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`endif

>>> rtl/core/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and the byte encoding function
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int UNIT_W      = 16;
    localparam int CP_W        = 21;
    localparam int SURR_BITS   = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0]      SURR_HIGH_TAG = 6'h36;
    localparam logic [5:0]      SURR_LOW_TAG  = 6'h37;
    localparam logic [CP_W-1:0] SUPP_BASE     = 21'h10000;

    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } t_len;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        t_len            len;
    } t_cp_entry;

    typedef struct packed {
        logic push;
        logic held_valid;
        logic low_surr;
    } t_front_stat;

    // byte idx of the utf-8 sequence for code point cp
    function automatic logic [7:0] encode_byte(input logic [CP_W-1:0] cp,
                                               input t_len            len,
                                               input logic [1:0]      idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: begin
                case (idx)
                    2'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_4: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/utf16_to_utf8_encoder.sv
// an accepted code unit's code point is written into the queue, and its first
// byte then goes from the queue head into the output register when that is free
// throughput: one output byte per cycle unless the receiver stalls; one unit per cycle
// enters until the code point queue (QUEUE_DEPTH entries) fills, then one unit per 1 to 4 bytes
// a high surrogate is held in the front and itself takes no queue entry
// reset: synchronous, active low; clears the held surrogate, queue and output
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// streaming utf-16 code unit to utf-8 byte converter
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [UNIT_W-1:0] i_s_tdata,   // code_unit[15:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // out_byte[7:0]
    output logic              o_m_tlast
);

    logic        s_accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_cp_entry   push_entry;
    t_cp_entry   head;
    t_front_stat front_stat;

    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    u16u8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_unit   (i_s_tdata),
        .o_push   (push),
        .o_entry  (push_entry),
        .o_stat   (front_stat)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

`include "assert_macros.svh"

    `CHK_CLK(a_lone_low_dropped, (s_accept && front_stat.low_surr && !front_stat.held_valid) |-> !push, "lone low surrogate pushed")
    `CHK_CLK(a_queue_drains, (!q_empty && (!o_m_tvalid || i_m_tready)) |=> o_m_tvalid, "queued code point not emitted")
    `CHK_ALWAYS(a_pop_needs_data, !(pop && q_empty), "pop from empty queue")
    `CHK_CLK(a_pop_on_last, pop |=> (o_m_tvalid && o_m_tlast), "pop without final byte")

endmodule

>>> rtl/core/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// takes code units, pairs surrogates and pushes code points with their length
// ----------------------------------------------------------------------------
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [UNIT_W-1:0] i_unit,
    output logic              o_push,
    output t_cp_entry         o_entry,
    output t_front_stat       o_stat
);

    logic                 r_held_valid;
    logic [SURR_BITS-1:0] r_held_bits;
    logic                 n_held_valid;
    logic [SURR_BITS-1:0] n_held_bits;
    logic                 is_high;
    logic                 is_low;

    assign is_high = (i_unit[UNIT_W-1:SURR_BITS] == SURR_HIGH_TAG);
    assign is_low  = (i_unit[UNIT_W-1:SURR_BITS] == SURR_LOW_TAG);

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        o_push       = 1'b0;
        o_entry.cp   = {{(CP_W-UNIT_W){1'b0}}, i_unit};
        o_entry.len  = LEN_3;
        if (i_unit[UNIT_W-1:7] == '0) begin
            o_entry.len = LEN_1;
        end else if (i_unit[UNIT_W-1:11] == '0) begin
            o_entry.len = LEN_2;
        end
        if (is_low) begin
            o_entry.cp  = SUPP_BASE + {1'b0, r_held_bits, i_unit[SURR_BITS-1:0]};
            o_entry.len = LEN_4;
        end
        if (i_accept) begin
            if (is_low) begin
                o_push       = r_held_valid;
                n_held_valid = 1'b0;
                n_held_bits  = '0;
            end else if (is_high) begin
                n_held_valid = 1'b1;
                n_held_bits  = i_unit[SURR_BITS-1:0];
            end else begin
                o_push       = 1'b1;
                n_held_valid = 1'b0;
                n_held_bits  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

    assign o_stat.push       = o_push;
    assign o_stat.held_valid = r_held_valid;
    assign o_stat.low_surr   = is_low;

endmodule

>>> rtl/core/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// short first-in first-out queue of code point entries
// ----------------------------------------------------------------------------
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cp_entry i_entry,
    input  logic      i_pop,
    output t_cp_entry o_head,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cp_entry              r_slot [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [PTR_W-1:0]       n_wr_ptr;
    logic [PTR_W-1:0]       n_rd_ptr;
    logic [CNT_W-1:0]       n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/core/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// walks the head code point byte by byte into the output register
// ----------------------------------------------------------------------------
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cp_entry i_head,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_tvalid,
    input  logic      i_tready,
    output logic [7:0] o_tdata,
    output logic      o_tlast
);

    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic [1:0] r_idx;
    logic       n_tvalid;
    logic [1:0] n_idx;
    logic       out_free;
    logic       emit;
    logic       at_last;

    assign out_free = !r_tvalid || i_tready;
    assign emit     = out_free && !i_empty;
    assign at_last  = (r_idx == 2'(i_head.len));
    assign o_pop    = emit && at_last;

    always_comb begin
        n_tvalid = r_tvalid;
        n_idx    = r_idx;
        if (out_free) begin
            n_tvalid = !i_empty;
        end
        if (emit) begin
            n_idx = at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            r_tvalid <= n_tvalid;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tdata <= encode_byte(i_head.cp, i_head.len, r_idx);
            r_tlast <= at_last;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

endmodule

>>> tb/utf16_to_utf8_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_tb
// drives utf-16 code units into the encoder and checks every utf-8 byte and
// its last flag against a local encoder model; directed corner units come
// first, then well-formed surrogate pairs mixed with bmp units, lone
// surrogates and raw noise, under random sender bursts and receiver stalls
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_tb;
    import u16u8_pkg::UNIT_W;

    localparam int RANDOM_UNITS = 380;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_BYTE = 120;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_byte_t;

    typedef struct {
        logic [UNIT_W-1:0] unit;
        bit                drain;
    } pending_unit_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [UNIT_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    pending_unit_t unit_queue[$];
    utf8_byte_t    utf8_expected[$];

    // local copy of the surrogate holding state
    logic [9:0] held_high;
    bit         held_valid;

    int mismatches  = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int bytes_seen  = 0;
    int stall_pct   = 0;
    int phase_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 0;
    int idle_cycles = 0;

    utf16_to_utf8_encoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // code_unit[15:0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // out_byte[7:0]
        .o_m_tlast  (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void push_byte(input logic [7:0] b, input logic last);
        utf8_byte_t e;
        e.data = b;
        e.last = last;
        utf8_expected.push_back(e);
    endfunction

    // expected bytes for one accepted code unit
    function automatic void encode_unit(input logic [UNIT_W-1:0] u);
        logic [20:0] cp;
        if (u >= 16'hDC00 && u <= 16'hDFFF) begin
            if (held_valid) begin
                cp = 21'h10000 + {1'b0, held_high, u[9:0]};
                held_valid = 0;
                held_high  = '0;
                push_byte({5'b11110, cp[20:18]}, 1'b0);
                push_byte({2'b10, cp[17:12]}, 1'b0);
                push_byte({2'b10, cp[11:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, 1'b1);
            end
        end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
            held_high  = u[9:0];
            held_valid = 1;
        end else begin
            held_valid = 0;
            held_high  = '0;
            if (u < 16'h0080) begin
                push_byte({1'b0, u[6:0]}, 1'b1);
            end else if (u < 16'h0800) begin
                push_byte({3'b110, u[10:6]}, 1'b0);
                push_byte({2'b10, u[5:0]}, 1'b1);
            end else begin
                push_byte({4'b1110, u[15:12]}, 1'b0);
                push_byte({2'b10, u[11:6]}, 1'b0);
                push_byte({2'b10, u[5:0]}, 1'b1);
            end
        end
    endfunction

    function automatic void add_unit(input logic [UNIT_W-1:0] u, input bit drain);
        pending_unit_t p;
        p.unit  = u;
        p.drain = drain;
        unit_queue.push_back(p);
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_unit(s_tdata);
                void'(unit_queue.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (unit_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (unit_queue[0].drain && utf8_expected.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= unit_queue[0].unit;
                    if (burst_left <= 1) begin
                        if ($urandom_range(3) == 0) begin
                            gap_left   = 0;
                            burst_left = $urandom_range(20, 60);
                        end else begin
                            gap_left   = $urandom_range(1, 6);
                            burst_left = $urandom_range(1, 10);
                        end
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk) begin
        utf8_byte_t e;
        logic       ready_next;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                bytes_seen++;
                if (utf8_expected.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got %02h last %0b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    e = utf8_expected.pop_front();
                    if (m_tdata !== e.data) begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, e.data, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== e.last) begin
                        $display("%0t: last_byte mismatch, expected %0b, got %0b",
                                 $time, e.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (phase_left == 0) begin
                case ($urandom_range(2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
                phase_left = $urandom_range(20, 120);
            end else begin
                phase_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
                hold_done  = 1;
                hold_left  = HOLD_CYCLES;
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(99) >= stall_pct);
            end
            m_tready <= ready_next;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        int         n;
        int         kind;
        bit         drain_next;
        logic [9:0] lo10;

        held_high  = '0;
        held_valid = 0;

        // directed corners
        add_unit(16'h0000, 0);
        add_unit(16'h007F, 0);
        add_unit(16'h0080, 0);
        add_unit(16'h07FF, 0);
        add_unit(16'h0800, 0);
        add_unit(16'hD7FF, 0);
        add_unit(16'hE000, 0);
        add_unit(16'hFFFF, 0);
        add_unit(16'hD800, 0);
        add_unit(16'hDC00, 0);
        add_unit(16'hDBFF, 0);
        add_unit(16'hDFFF, 0);
        // lone low surrogate
        add_unit(16'hDC00, 0);
        add_unit(16'hDFFF, 0);
        // unpaired high then bmp unit
        add_unit(16'hD800, 0);
        add_unit(16'h0041, 0);
        // high replaced by a newer high
        add_unit(16'hD801, 0);
        add_unit(16'hDBFF, 0);
        add_unit(16'hDC05, 0);
        // unpaired high then zero unit
        add_unit(16'hD812, 0);
        add_unit(16'h0000, 0);
        add_unit(16'hAAAA, 0);
        add_unit(16'h5555, 0);
        // high surrogate left pending across a pause
        add_unit(16'hDA55, 0);
        add_unit(16'hDDAA, 1);

        n = 0;
        drain_next = 0;
        while (n < RANDOM_UNITS) begin
            if (n == 150 || n == 300)
                drain_next = 1;
            kind = $urandom_range(99);
            if (kind < 45) begin
                lo10 = 10'($urandom_range(1023));
                add_unit(UNIT_W'(16'hD800 | $urandom_range(1023)), drain_next);
                add_unit({6'b110111, lo10}, 0);
                n += 2;
            end else begin
                if (kind < 60)
                    add_unit(UNIT_W'($urandom_range(16'h007F)), drain_next);
                else if (kind < 70)
                    add_unit(UNIT_W'($urandom_range(16'h07FF, 16'h0080)), drain_next);
                else if (kind < 80)
                    add_unit(UNIT_W'($urandom_range(16'hD7FF, 16'h0800)), drain_next);
                else if (kind < 85)
                    add_unit(UNIT_W'($urandom_range(16'hFFFF, 16'hE000)), drain_next);
                else if (kind < 90)
                    add_unit(UNIT_W'(16'hD800 | $urandom_range(1023)), drain_next);
                else if (kind < 94)
                    add_unit(UNIT_W'(16'hDC00 | $urandom_range(1023)), drain_next);
                else
                    add_unit(UNIT_W'($urandom_range(16'hFFFF)), drain_next);
                n++;
            end
            drain_next = 0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (unit_queue.size() != 0 || s_tvalid || utf8_expected.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (utf8_expected.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, utf8_expected.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
